@@ sv/stack_alu_binary_ops_core_macros.svh @@
// Assertion macros shared by the stack ALU checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef STACK_ALU_BINARY_OPS_CORE_MACROS_SVH
`define STACK_ALU_BINARY_OPS_CORE_MACROS_SVH

// same-cycle implication
`define SALU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stack alu check failed");

// next-cycle implication
`define SALU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stack alu check failed");

`endif

@@ sv/salu_pkg.sv @@
// Shared types and constants for the stack ALU core.
// No dependencies.
`timescale 1ns / 1ps

package salu_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int DEPTH_W         = 7;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_SWAP = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_SUB  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_MUL  = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_SWAP2,
        S_MULWR,
        S_DIVRUN,
        S_DONE
    } t_state;

endpackage

@@ sv/salu_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module salu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/salu_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on salu_pkg.
`timescale 1ns / 1ps

module salu_div import salu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;

    logic [DATA_W-1:0] n_rem;
    logic [DATA_W-1:0] n_quo;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;

    // remainder stays below the divisor magnitude, so it fits in DATA_W bits
    always_comb begin
        w_shift = {r_rem, r_quo[DATA_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        if (!w_diff[DATA_W]) begin
            n_rem = w_diff[DATA_W-1:0];
            n_quo = {r_quo[DATA_W-2:0], 1'b1};
        end else begin
            n_rem = w_shift[DATA_W-1:0];
            n_quo = {r_quo[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands are taken as magnitudes; sign fixed on the way out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[DATA_W-1] ? (DATA_W'(0) - i_num) : i_num;
            r_den <= i_den[DATA_W-1] ? (DATA_W'(0) - i_den) : i_den;
            r_neg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

endmodule

@@ sv/stack_alu_binary_ops_core.sv @@
// Stack ALU core: one command word in, one result word out, sequential.
// Sequence from accept: push, errors and unused codes go from execute straight to done;
// add/sub also read the second entry, swap and mul then pass S_SWAP2 / S_MULWR, div waits on the 32-step divider loop.
// One word in flight; the next word is taken once the result has entered the output
// register, which S_DONE loads only while the previous result is not stalled.
// Reset (synchronous, active low) empties the stack; stack RAM contents are not cleared.
`timescale 1ns / 1ps

module stack_alu_binary_ops_core import salu_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] command, [34:3] push_value, [39:35] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, [33:2] top_value, [40:34] stack_depth, [47:41] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_state            r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [DATA_W-1:0] r_val, n_val;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_top, n_top;
    logic [DATA_W-1:0] r_sec, n_sec;
    logic [DATA_W-1:0] r_res, n_res;
    t_status           r_status, n_status;
    logic              r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;
    logic [CW-1:0]     w_cnt_m1;
    logic [CW-1:0]     w_cnt_m2;
    logic [2*DATA_W-1:0] w_prod;
    logic [CW+DEPTH_W-1:0] w_depth_ext;
    logic [DATA_W-1:0] w_top_out;
    logic              w_div_start;
    logic              w_div_done;
    logic [DATA_W-1:0] w_div_quot;

    salu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    salu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_rdata),
        .i_den   (r_top),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign w_cnt_m1    = r_count - CW'(1);
    assign w_cnt_m2    = r_count - CW'(2);
    assign w_prod      = w_rdata * r_top;
    assign w_depth_ext = {{DEPTH_W{1'b0}}, r_count};
    assign w_top_out   = (r_count == '0) ? '0 : r_top;
    assign w_raddr     = w_cnt_m2[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_count     = r_count;
        n_top       = r_top;
        n_sec       = r_sec;
        n_res       = r_res;
        n_status    = r_status;
        n_odata     = r_odata;
        n_ovalid    = r_ovalid && !m_axis_tready;
        w_we        = 1'b0;
        w_waddr     = w_cnt_m2[AW-1:0];
        w_wdata     = r_top;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tdata[CMD_W-1:0];
                    n_val   = s_axis_tdata[CMD_W +: DATA_W];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_state  = S_DONE;
                case (r_cmd)
                    CMD_PUSH: begin
                        if (r_count == CW'(STACK_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_count[AW-1:0];
                            w_wdata = r_val;
                            n_top   = r_val;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL: begin
                        if (r_count < CW'(2)) begin
                            n_status = ST_SHORT;
                        end else if (r_cmd == CMD_DIV && r_top == '0) begin
                            n_status = ST_DIVZERO;
                        end else begin
                            // second entry read issued via w_raddr
                            n_state = S_RDATA;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_RDATA: begin
                n_sec   = w_rdata;
                n_state = S_DONE;
                case (r_cmd)
                    CMD_SWAP: begin
                        w_we    = 1'b1;
                        w_waddr = w_cnt_m1[AW-1:0];
                        w_wdata = w_rdata;
                        n_state = S_SWAP2;
                    end
                    CMD_ADD: begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata + r_top;
                        n_top   = w_rdata + r_top;
                        n_count = w_cnt_m1;
                    end
                    CMD_SUB: begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata - r_top;
                        n_top   = w_rdata - r_top;
                        n_count = w_cnt_m1;
                    end
                    CMD_MUL: begin
                        n_res   = w_prod[DATA_W-1:0];
                        n_state = S_MULWR;
                    end
                    CMD_DIV: begin
                        w_div_start = 1'b1;
                        n_state     = S_DIVRUN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SWAP2: begin
                w_we    = 1'b1;
                w_wdata = r_top;
                n_top   = r_sec;
                n_state = S_DONE;
            end
            S_MULWR: begin
                w_we    = 1'b1;
                w_wdata = r_res;
                n_top   = r_res;
                n_count = w_cnt_m1;
                n_state = S_DONE;
            end
            S_DIVRUN: begin
                if (w_div_done) begin
                    w_we    = 1'b1;
                    w_wdata = w_div_quot;
                    n_top   = w_div_quot;
                    n_count = w_cnt_m1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {{(OUT_TDATA_W - DEPTH_W - DATA_W - STATUS_W){1'b0}},
                                w_depth_ext[DEPTH_W-1:0], w_top_out, r_status};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_val    <= n_val;
        r_top    <= n_top;
        r_sec    <= n_sec;
        r_res    <= n_res;
        r_status <= n_status;
        r_odata  <= n_odata;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

@@ sv/salu_chk.sv @@
// Port-level checker for the stack ALU core, bound to the top level.
// Depends on salu_pkg and stack_alu_binary_ops_core_macros.svh.
`timescale 1ns / 1ps
`include "stack_alu_binary_ops_core_macros.svh"

module salu_chk import salu_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result word holds
    `SALU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // one word at a time: input closes right after an accept
    `SALU_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // too-short status only with fewer than two entries
    `SALU_ASSERT_IMPL(a_short_depth, m_axis_tvalid && m_axis_tdata[1:0] == ST_SHORT, m_axis_tdata[40:34] < 7'd2)
    // division by zero leaves the zero divisor on top
    `SALU_ASSERT_IMPL(a_divzero_top, m_axis_tvalid && m_axis_tdata[1:0] == ST_DIVZERO, m_axis_tdata[33:2] == 32'd0)

endmodule

bind stack_alu_binary_ops_core salu_chk u_salu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
